// ===== hw/rtl/dcmt_pkg.sv =====
`timescale 1ns / 1ps

package dcmt_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int OUT_FRAC_BITS_DEF   = 14;

	// signed container wide enough for a doubled strike
	localparam int ANGLE_W      = 18;
	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_W     = 33;
	localparam int TRIG_W       = 32;
	localparam int CORDIC_START = 652032874;
	localparam int TRIG_ONE     = 1 << 30;

	localparam int ANGLE_LAT  = 3;
	localparam int TRIG_LAT   = ANGLE_LAT + CORDIC_STEPS + 1;
	localparam int TENSOR_LAT = 4;
	localparam int PIPE_LAT   = TRIG_LAT + TENSOR_LAT;

	typedef struct packed {
		logic [15:0]        strike_angle;
		logic [13:0]        dip_angle;
		logic signed [15:0] rake_angle;
	} mech_t;

	typedef struct packed {
		logic signed [15:0] m_xx;
		logic signed [15:0] m_yy;
		logic signed [15:0] m_zz;
		logic signed [15:0] m_xy;
		logic signed [15:0] m_xz;
		logic signed [15:0] m_yz;
		logic signed [15:0] m_tp;
		logic signed [15:0] m_rp;
	} tensor_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		logic [1:0]                 quad;
	} cordic_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} trig_t;

	// arctan(2^-i) in units of 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
		logic signed [CORDIC_W-1:0] v;
		case (i)
			0:  v = 33'sd536870912;
			1:  v = 33'sd316933406;
			2:  v = 33'sd167458907;
			3:  v = 33'sd85004756;
			4:  v = 33'sd42667331;
			5:  v = 33'sd21354465;
			6:  v = 33'sd10679838;
			7:  v = 33'sd5340245;
			8:  v = 33'sd2670163;
			9:  v = 33'sd1335087;
			10: v = 33'sd667544;
			11: v = 33'sd333772;
			12: v = 33'sd166886;
			13: v = 33'sd83443;
			14: v = 33'sd41722;
			15: v = 33'sd20861;
			16: v = 33'sd10430;
			17: v = 33'sd5215;
			18: v = 33'sd2608;
			19: v = 33'sd1304;
			20: v = 33'sd652;
			21: v = 33'sd326;
			22: v = 33'sd163;
			23: v = 33'sd81;
			24: v = 33'sd41;
			25: v = 33'sd20;
			26: v = 33'sd10;
			27: v = 33'sd5;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/dcmt_angle.sv =====
`timescale 1ns / 1ps

module dcmt_angle #(
	parameter int ANGLE_FRAC_BITS = dcmt_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [dcmt_pkg::ANGLE_W-1:0]  angle,
	output dcmt_pkg::cordic_t                    start
);
	import dcmt_pkg::*;

	// full turn is 45 * 2^LOW_W angle units
	localparam int LOW_W    = ANGLE_FRAC_BITS + 3;
	localparam int HI_W     = ANGLE_W - LOW_W;
	localparam int HOFS     = 45 * (1 << HI_W);
	localparam int HP_W     = HI_W + 6;
	localparam int R_W      = 6 + LOW_W;
	localparam int RECIP    = 93206;
	localparam int RECIP_W  = 17;
	localparam int RECIP_SH = 22;
	localparam int K        = 29 - ANGLE_FRAC_BITS;

	logic [31:0] frac_c [64];

	for (genvar g = 0; g < 64; g++) begin : g_frac
		localparam longint FV = ((longint'(g) << (K + 1)) + 45) / 90;
		assign frac_c[g] = 32'(FV);
	end

	logic signed [ANGLE_W-1:0] hi_c;
	logic [HP_W-1:0]           hp_c;
	logic [HP_W+RECIP_W-1:0]   hprod_c;
	logic [HP_W-1:0]           hq_c;
	logic [6:0]                hr_c;

	logic [5:0]       rem_s1;
	logic [LOW_W-1:0] low_s1;

	// high part of the angle modulo 45 turns the angle modulo a full turn
	always_comb begin
		hi_c    = angle >>> LOW_W;
		hp_c    = HP_W'(int'(hi_c) + HOFS);
		hprod_c = (HP_W+RECIP_W)'(hp_c) * (HP_W+RECIP_W)'(RECIP);
		hq_c    = HP_W'(hprod_c >> RECIP_SH);
		hr_c    = 7'(hp_c - HP_W'(hq_c * HP_W'(45)));
		if (hr_c >= 7'd45)
			hr_c = hr_c - 7'd45;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= 6'(hr_c);
			low_s1 <= angle[LOW_W-1:0];
		end
	end

	logic [R_W-1:0]         r_c;
	logic [R_W+RECIP_W-1:0] rprod_c;
	logic [R_W-1:0]         aq_c;
	logic [6:0]             ar_c;

	logic [LOW_W-1:0] a_s2;
	logic [5:0]       b_s2;

	// reduced angle = 45 * a + b
	always_comb begin
		r_c     = {rem_s1, low_s1};
		rprod_c = (R_W+RECIP_W)'(r_c) * (R_W+RECIP_W)'(RECIP);
		aq_c    = R_W'(rprod_c >> RECIP_SH);
		ar_c    = 7'(r_c - R_W'(aq_c * R_W'(45)));
		if (ar_c >= 7'd45) begin
			ar_c = ar_c - 7'd45;
			aq_c = aq_c + R_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= LOW_W'(aq_c);
			b_s2 <= 6'(ar_c);
		end
	end

	logic [31:0] phase_c;
	logic [31:0] qsum_c;
	logic [1:0]  quad_c;
	logic [31:0] res_c;

	logic [1:0]                 quad_s3;
	logic signed [CORDIC_W-1:0] z_s3;

	// nearest quarter turn and a residue within one eighth turn
	always_comb begin
		phase_c = 32'((64'(a_s2) << K) + 64'(frac_c[b_s2]));
		qsum_c  = phase_c + 32'h2000_0000;
		quad_c  = qsum_c[31:30];
		res_c   = phase_c - {quad_c, 30'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s3 <= quad_c;
			z_s3    <= {res_c[31], res_c};
		end
	end

	assign start.x    = CORDIC_W'(CORDIC_START);
	assign start.y    = '0;
	assign start.z    = z_s3;
	assign start.quad = quad_s3;

endmodule

// ===== hw/rtl/dcmt_cell.sv =====
`timescale 1ns / 1ps

module dcmt_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  dcmt_pkg::cordic_t prev,
	output dcmt_pkg::cordic_t step_q
);
	import dcmt_pkg::*;

	localparam logic signed [CORDIC_W-1:0] ATAN = atan_turn(STEP);

	logic signed [CORDIC_W-1:0] xs_c;
	logic signed [CORDIC_W-1:0] ys_c;
	cordic_t                    nxt_c;

	always_comb begin
		xs_c       = $signed(prev.x) >>> STEP;
		ys_c       = $signed(prev.y) >>> STEP;
		nxt_c.quad = prev.quad;
		if (!prev.z[CORDIC_W-1]) begin
			nxt_c.x = prev.x - ys_c;
			nxt_c.y = prev.y + xs_c;
			nxt_c.z = prev.z - ATAN;
		end else begin
			nxt_c.x = prev.x + ys_c;
			nxt_c.y = prev.y - xs_c;
			nxt_c.z = prev.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			step_q <= nxt_c;
	end

endmodule

// ===== hw/rtl/dcmt_trig.sv =====
`timescale 1ns / 1ps

module dcmt_trig #(
	parameter int ANGLE_FRAC_BITS = dcmt_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [dcmt_pkg::ANGLE_W-1:0] angle,
	output dcmt_pkg::trig_t                     cs_q
);
	import dcmt_pkg::*;

	localparam logic signed [CORDIC_W-1:0] ONE_P = CORDIC_W'(TRIG_ONE);
	localparam logic signed [CORDIC_W-1:0] ONE_N = -ONE_P;

	cordic_t chain [CORDIC_STEPS+1];

	dcmt_angle #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_angle (
		.clk  (clk),
		.en   (en),
		.angle(angle),
		.start(chain[0])
	);

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		dcmt_cell #(
			.STEP(g)
		) u_cell (
			.clk   (clk),
			.en    (en),
			.prev  (chain[g]),
			.step_q(chain[g+1])
		);
	end

	cordic_t                  last_c;
	logic signed [TRIG_W-1:0] xc_c;
	logic signed [TRIG_W-1:0] yc_c;
	trig_t                    cs_c;

	always_comb begin
		last_c = chain[CORDIC_STEPS];
		if (last_c.x > ONE_P)
			xc_c = TRIG_W'(ONE_P);
		else if (last_c.x < ONE_N)
			xc_c = TRIG_W'(ONE_N);
		else
			xc_c = TRIG_W'(last_c.x);
		if (last_c.y > ONE_P)
			yc_c = TRIG_W'(ONE_P);
		else if (last_c.y < ONE_N)
			yc_c = TRIG_W'(ONE_N);
		else
			yc_c = TRIG_W'(last_c.y);
		unique case (last_c.quad)
			2'd0: begin
				cs_c.c = xc_c;
				cs_c.s = yc_c;
			end
			2'd1: begin
				cs_c.c = -yc_c;
				cs_c.s = xc_c;
			end
			2'd2: begin
				cs_c.c = -xc_c;
				cs_c.s = -yc_c;
			end
			2'd3: begin
				cs_c.c = yc_c;
				cs_c.s = -xc_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			cs_q <= cs_c;
	end

endmodule

// ===== hw/rtl/dcmt_tensor.sv =====
`timescale 1ns / 1ps

module dcmt_tensor #(
	parameter int OUT_FRAC_BITS = dcmt_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  dcmt_pkg::trig_t   strike,
	input  dcmt_pkg::trig_t   strike2,
	input  dcmt_pkg::trig_t   dip,
	input  dcmt_pkg::trig_t   dip2,
	input  dcmt_pkg::trig_t   rake,
	output dcmt_pkg::tensor_t tensor_q
);
	import dcmt_pkg::*;

	localparam int SUM_W  = TRIG_W + 2;
	localparam int RND_W  = SUM_W + 1;
	localparam int SH     = 30 - OUT_FRAC_BITS;
	localparam int RND_SH = (SH == 0) ? 0 : SH - 1;
	localparam logic signed [RND_W-1:0] HALF =
		(SH == 0) ? RND_W'(0) : (RND_W'(1) <<< RND_SH);

	function automatic logic signed [TRIG_W-1:0] mulq(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b,
		input int                       sh
	);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + (64'sd1 <<< (sh - 1));
		return TRIG_W'(p >>> sh);
	endfunction

	function automatic logic signed [RND_W-1:0] rnd(input logic signed [SUM_W-1:0] v);
		return (RND_W'(v) + HALF) >>> SH;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [RND_W:0] v);
		logic signed [15:0] r;
		if (v > (RND_W+1)'(32767))
			r = 16'sd32767;
		else if (v < -(RND_W+1)'(32768))
			r = -16'sd32768;
		else
			r = 16'(v);
		return r;
	endfunction

	// first products
	logic signed [TRIG_W-1:0] dc_s1, r2d_s1, ss_s1, cc_s1, cdc_s1, c2ds_s1;
	trig_t                    st_s1, st2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s1   <= mulq(dip.s, rake.c, 30);
			r2d_s1  <= mulq(dip2.s, rake.s, 30);
			ss_s1   <= mulq(strike.s, strike.s, 30);
			cc_s1   <= mulq(strike.c, strike.c, 30);
			cdc_s1  <= mulq(dip.c, rake.c, 30);
			c2ds_s1 <= mulq(dip2.c, rake.s, 30);
			st_s1   <= strike;
			st2_s1  <= strike2;
		end
	end

	// second products
	logic signed [TRIG_W-1:0] t1_s2, t2_s2, t3_s2, t4_s2, t5_s2, t6_s2, t7_s2, t8_s2, t9_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2 <= mulq(dc_s1, st2_s1.s, 30);
			t2_s2 <= mulq(r2d_s1, ss_s1, 30);
			t3_s2 <= mulq(r2d_s1, cc_s1, 30);
			t4_s2 <= mulq(dc_s1, st2_s1.c, 30);
			t5_s2 <= mulq(r2d_s1, st2_s1.s, 31);
			t6_s2 <= mulq(cdc_s1, st_s1.c, 30);
			t7_s2 <= mulq(c2ds_s1, st_s1.s, 30);
			t8_s2 <= mulq(cdc_s1, st_s1.s, 30);
			t9_s2 <= mulq(c2ds_s1, st_s1.c, 30);
		end
	end

	// components in Q30; mzz = -(mxx + myy) reduces to t2 + t3
	logic signed [SUM_W-1:0] xx_s3, yy_s3, zz_s3, xy_s3, xz_s3, yz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s3 <= -(SUM_W'(t1_s2) + SUM_W'(t2_s2));
			yy_s3 <= SUM_W'(t1_s2) - SUM_W'(t3_s2);
			zz_s3 <= SUM_W'(t2_s2) + SUM_W'(t3_s2);
			xy_s3 <= SUM_W'(t4_s2) + SUM_W'(t5_s2);
			xz_s3 <= -(SUM_W'(t6_s2) + SUM_W'(t7_s2));
			yz_s3 <= -(SUM_W'(t8_s2) - SUM_W'(t9_s2));
		end
	end

	logic signed [RND_W-1:0] rxy_c;
	logic signed [RND_W-1:0] ryz_c;
	tensor_t                 out_c;

	always_comb begin
		rxy_c      = rnd(xy_s3);
		ryz_c      = rnd(yz_s3);
		out_c.m_xx = sat16((RND_W+1)'(rnd(xx_s3)));
		out_c.m_yy = sat16((RND_W+1)'(rnd(yy_s3)));
		out_c.m_zz = sat16((RND_W+1)'(rnd(zz_s3)));
		out_c.m_xy = sat16((RND_W+1)'(rxy_c));
		out_c.m_xz = sat16((RND_W+1)'(rnd(xz_s3)));
		out_c.m_yz = sat16((RND_W+1)'(ryz_c));
		out_c.m_tp = sat16(-((RND_W+1)'(rxy_c)));
		out_c.m_rp = sat16(-((RND_W+1)'(ryz_c)));
	end

	always_ff @(posedge clk) begin
		if (en)
			tensor_q <= out_c;
	end

endmodule

// ===== hw/rtl/double_couple_to_moment_tensor.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                 word
// mech      in         mech_valid / mech_stall   mech_t: strike, dip, rake
// tensor    out        tensor_valid / tensor_stall  tensor_t: eight components
//
// one word per cycle unless a result is held under tensor_stall; each word passes through angle reduction,
// one register per CORDIC cell (28), a quadrant fixup register and the product tree.
// the whole pipe advances together; it freezes only while a result is held
// under tensor_stall, and mech_stall follows from that.
// arst_n clears the valid bits only; the data registers are not reset.
module double_couple_to_moment_tensor #(
	parameter int ANGLE_FRAC_BITS = dcmt_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS   = dcmt_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mech_valid,
	output logic              mech_stall,
	input  dcmt_pkg::mech_t   mech,
	output logic              tensor_valid,
	input  logic              tensor_stall,
	output dcmt_pkg::tensor_t tensor
);
	import dcmt_pkg::*;

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	assign tensor_valid = vld_q[PIPE_LAT-1];
	assign en           = !(tensor_valid && tensor_stall);
	assign mech_stall   = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_LAT-2:0], mech_valid};
	end

	logic signed [ANGLE_W-1:0] ang_c [5];
	trig_t                     cs_c  [5];

	assign ang_c[0] = {2'b00, mech.strike_angle};
	assign ang_c[1] = {1'b0, mech.strike_angle, 1'b0};
	assign ang_c[2] = {4'b0000, mech.dip_angle};
	assign ang_c[3] = {3'b000, mech.dip_angle, 1'b0};
	assign ang_c[4] = {{2{mech.rake_angle[15]}}, mech.rake_angle};

	for (genvar g = 0; g < 5; g++) begin : g_trig
		dcmt_trig #(
			.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
		) u_trig (
			.clk  (clk),
			.en   (en),
			.angle(ang_c[g]),
			.cs_q (cs_c[g])
		);
	end

	dcmt_tensor #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_tensor (
		.clk     (clk),
		.en      (en),
		.strike  (cs_c[0]),
		.strike2 (cs_c[1]),
		.dip     (cs_c[2]),
		.dip2    (cs_c[3]),
		.rake    (cs_c[4]),
		.tensor_q(tensor)
	);

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[PIPE_LAT-2] && !tensor_stall) |=> tensor_valid)
		else $error("word lost at the last pipeline stage");

	a_tp_neg: assert property (@(posedge clk) disable iff (!arst_n)
		tensor_valid |-> (16'(tensor.m_tp + tensor.m_xy) == 16'h0000 ||
			16'(tensor.m_tp + tensor.m_xy) == 16'hffff))
		else $error("m_tp is not the negation of m_xy");

	a_rp_neg: assert property (@(posedge clk) disable iff (!arst_n)
		tensor_valid |-> (16'(tensor.m_rp + tensor.m_yz) == 16'h0000 ||
			16'(tensor.m_rp + tensor.m_yz) == 16'hffff))
		else $error("m_rp is not the negation of m_yz");

endmodule
